FILE: rtl/rar_pkg.sv
// types, constants and helpers for the rational arithmetic reduce block
// used by rational_arithmetic_reduce; depends on nothing else
package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int VAL_W = 2 * OPERAND_WIDTH;
  localparam int CNT_W = $clog2(VAL_W);
  localparam int SHF_W = $clog2(VAL_W + 1);
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int EXT_W = (VAL_W + 1 > NUM_W) ? VAL_W + 1 : NUM_W;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_GCD_TWO,
    S_GCD,
    S_DIV_NUM,
    S_DIV_DEN,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e                           kind;
    logic signed [OPERAND_WIDTH-1:0] first_num;
    logic signed [OPERAND_WIDTH-1:0] first_den;
    logic signed [OPERAND_WIDTH-1:0] second_num;
    logic signed [OPERAND_WIDTH-1:0] second_den;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] result_num;
    logic [DEN_W-1:0]        result_den;
    logic                    status;
  } out_item_t;

  // magnitude of a two's complement operand, exact for the most negative value
  function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    mag_of = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

FILE: rtl/rational_arithmetic_reduce.sv
// rational add/sub/mul/div with reduction to lowest terms
// depends on rar_pkg
//
//  channel  direction  payload     handshake
//  in       input      in_item_t   in_valid_i, in_stall_o
//  out      output     out_item_t  out_valid_o, out_stall_i
//
// one transaction at a time: the multiply steps through one shared multiplier, a sum step,
// stripping of common factors of two, a binary gcd (shift or subtract steps on the
// shared subtractor) and two restoring divisions on that same subtractor, then the done
// state and the idle state
// zero-denominator and zero-numerator results skip gcd and division
// in_stall_o is high from acceptance until the result has been taken
// reset clears the sequencer only; the result holds while out_stall_i is high
module rational_arithmetic_reduce
  import rar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int W = OPERAND_WIDTH;

  state_e state_q, state_d;

  in_item_t          op_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [VAL_W-1:0]  t0_q, t0_d, t1_q, t1_d, den_q, den_d;
  logic              t0_neg_q, t0_neg_d, t1_neg_q, t1_neg_d, den_neg_q, den_neg_d;
  logic [VAL_W-1:0]  a_q, a_d, b_q, b_d, g_q, g_d, x_q, x_d, rem_q, rem_d, nq_q, nq_d;
  logic [SHF_W-1:0]  k_q, k_d;
  logic              neg_q, neg_d;
  out_item_t         res_q, res_d;

  // operand magnitudes and signs
  logic [W-1:0] n1_m, d1_m, n2_m, d2_m;
  logic         n1_s, d1_s, n2_s, d2_s;

  assign n1_m = mag_of(op_q.first_num);
  assign d1_m = mag_of(op_q.first_den);
  assign n2_m = mag_of(op_q.second_num);
  assign d2_m = mag_of(op_q.second_den);
  assign n1_s = op_q.first_num[W-1];
  assign d1_s = op_q.first_den[W-1];
  assign n2_s = op_q.second_num[W-1];
  assign d2_s = op_q.second_den[W-1];

  // shared multiplier with operand select by step
  logic [W-1:0]     mul_a, mul_b;
  logic             mul_s;
  logic [VAL_W-1:0] prod;

  always_comb begin
    mul_a = d1_m;
    mul_b = (op_q.kind == KIND_DIV) ? n2_m : d2_m;
    mul_s = d1_s ^ ((op_q.kind == KIND_DIV) ? n2_s : d2_s);
    if (cnt_q == CNT_W'(0)) begin
      mul_a = n1_m;
      mul_b = (op_q.kind == KIND_MUL) ? n2_m : d2_m;
      mul_s = n1_s ^ ((op_q.kind == KIND_MUL) ? n2_s : d2_s);
    end else if (cnt_q == CNT_W'(1)) begin
      mul_a = n2_m;
      mul_b = d1_m;
      mul_s = n2_s ^ d1_s ^ (op_q.kind == KIND_SUB);
    end
  end

  assign prod = VAL_W'(mul_a) * VAL_W'(mul_b);

  // shared subtractor with operand select by state
  logic [VAL_W:0] sub_x, sub_y, sub_r, shifted;
  logic [VAL_W-1:0] sub_neg;
  logic           borrow;

  assign shifted = {rem_q, x_q[VAL_W-1]};

  always_comb begin
    unique case (state_q)
      S_SUM: begin
        sub_x = {1'b0, t0_q};
        sub_y = {1'b0, t1_q};
      end
      S_DIV_NUM, S_DIV_DEN: begin
        sub_x = shifted;
        sub_y = {1'b0, g_q};
      end
      default: begin
        sub_x = {1'b0, a_q};
        sub_y = {1'b0, b_q};
      end
    endcase
  end

  assign sub_r   = sub_x - sub_y;
  assign borrow  = sub_r[VAL_W];
  assign sub_neg = ~sub_r[VAL_W-1:0] + 1'b1;

  // signed sum of the two cross products
  logic [VAL_W-1:0] sum_mag;
  logic             sum_neg;

  always_comb begin
    if (t0_neg_q == t1_neg_q) begin
      sum_mag = t0_q + t1_q;
      sum_neg = t0_neg_q;
    end else if (!borrow) begin
      sum_mag = sub_r[VAL_W-1:0];
      sum_neg = t0_neg_q;
    end else begin
      sum_mag = sub_neg;
      sum_neg = t1_neg_q;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  logic last_bit;
  assign last_bit = (cnt_q == CNT_W'(VAL_W - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_MUL;
      S_MUL:     if (cnt_q == CNT_W'(2)) state_d = S_SUM;
      S_SUM: begin
        if (den_q == '0 || sum_mag == '0) state_d = S_DONE;
        else                              state_d = S_GCD_TWO;
      end
      S_GCD_TWO: if (a_q[0] || b_q[0]) state_d = S_GCD;
      S_GCD:     if (a_q == '0) state_d = S_DIV_NUM;
      S_DIV_NUM: if (last_bit) state_d = S_DIV_DEN;
      S_DIV_DEN: if (last_bit) state_d = S_DONE;
      S_DONE:    if (!out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath
  logic [EXT_W-1:0] wide_num;

  always_comb begin
    cnt_d = cnt_q;
    t0_d = t0_q; t0_neg_d = t0_neg_q;
    t1_d = t1_q; t1_neg_d = t1_neg_q;
    den_d = den_q; den_neg_d = den_neg_q;
    a_d = a_q; b_d = b_q; g_d = g_q; k_d = k_q;
    x_d = x_q; rem_d = rem_q; nq_d = nq_q;
    neg_d = neg_q;
    res_d = res_q;
    wide_num = EXT_W'(nq_q);
    unique case (state_q)
      S_IDLE: cnt_d = '0;
      // three products, one per cycle
      S_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(0)) begin
          t0_d = prod;
          t0_neg_d = mul_s && (prod != '0);
        end else if (cnt_q == CNT_W'(1)) begin
          if (op_q.kind == KIND_ADD || op_q.kind == KIND_SUB) begin
            t1_d = prod;
            t1_neg_d = mul_s && (prod != '0);
          end else begin
            t1_d = '0;
            t1_neg_d = 1'b0;
          end
        end else begin
          den_d = prod;
          den_neg_d = mul_s && (prod != '0);
        end
      end
      // combine and catch special cases
      S_SUM: begin
        a_d = sum_mag;
        b_d = den_q;
        k_d = '0;
        neg_d = sum_neg ^ den_neg_q;
        if (den_q == '0) begin
          res_d.result_num = '0;
          res_d.result_den = '0;
          res_d.status = 1'b1;
        end else if (sum_mag == '0) begin
          res_d.result_num = '0;
          res_d.result_den = DEN_W'(1);
          res_d.status = 1'b0;
        end
      end
      // strip common factors of two
      S_GCD_TWO: begin
        if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end
      end
      // binary gcd on odd parts
      S_GCD: begin
        cnt_d = '0;
        if (a_q == '0) begin
          g_d = b_q << k_q;
          x_d = t0_q;
          rem_d = '0;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (!borrow) begin
          a_d = sub_r[VAL_W-1:0];
        end else begin
          b_d = sub_neg;
        end
      end
      // restoring division, one quotient bit a cycle
      S_DIV_NUM, S_DIV_DEN: begin
        cnt_d = cnt_q + 1'b1;
        rem_d = borrow ? shifted[VAL_W-1:0] : sub_r[VAL_W-1:0];
        x_d = {x_q[VAL_W-2:0], ~borrow};
        if (last_bit) begin
          cnt_d = '0;
          rem_d = '0;
          if (state_q == S_DIV_NUM) begin
            nq_d = x_d;
            x_d = den_q;
          end else begin
            wide_num = neg_q ? (~EXT_W'(nq_q) + 1'b1) : EXT_W'(nq_q);
            res_d.result_num = wide_num[NUM_W-1:0];
            res_d.result_den = DEN_W'(x_d);
            res_d.status = 1'b0;
          end
        end
      end
      default: ;
    endcase
    // numerator dividend comes from the sum, kept in t0
    if (state_q == S_SUM) t0_d = sum_mag;
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) op_q <= in_data_i;
    cnt_q <= cnt_d;
    t0_q <= t0_d; t0_neg_q <= t0_neg_d;
    t1_q <= t1_d; t1_neg_q <= t1_neg_d;
    den_q <= den_d; den_neg_q <= den_neg_d;
    a_q <= a_d; b_q <= b_d; g_q <= g_d; k_q <= k_d;
    x_q <= x_d; rem_q <= rem_d; nq_q <= nq_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  // handshake outputs
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign out_data_o  = res_q;

  // an error result carries zeros
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.result_num == '0 &&
      out_data_o.result_den == '0)
    else $error("error result not zeroed");

  // a good result has a nonzero denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.status |-> out_data_o.result_den != '0)
    else $error("zero denominator on good result");

  // an accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("not busy after acceptance");

endmodule

FILE: dv/rational_arithmetic_reduce_tb.sv
// testbench for rational_arithmetic_reduce: directed and random fraction transactions
// depends on rar_pkg and the rational_arithmetic_reduce rtl
`timescale 1ns / 100ps

module rational_arithmetic_reduce_tb
  import rar_pkg::*;
();

  // scoreboard of expected reduced fractions
  class fraction_board;
    out_item_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint unsigned euclid(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    // work out the reduced fraction for one accepted input
    function void note_input(in_item_t it);
      longint signed n1, d1, n2, d2, num, den;
      longint unsigned nm, dm, g;
      bit neg;
      out_item_t r;
      n1 = it.first_num; d1 = it.first_den;
      n2 = it.second_num; d2 = it.second_den;
      case (it.kind)
        KIND_ADD: begin num = n1 * d2 + n2 * d1; den = d1 * d2; end
        KIND_SUB: begin num = n1 * d2 - n2 * d1; den = d1 * d2; end
        KIND_MUL: begin num = n1 * n2; den = d1 * d2; end
        default:  begin num = n1 * d2; den = d1 * n2; end
      endcase
      r = '0;
      if (den == 0) begin
        r.status = 1'b1;
      end else if (num == 0) begin
        r.result_den = DEN_W'(1);
      end else begin
        neg = (num < 0) != (den < 0);
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        g = euclid(nm, dm);
        nm = nm / g;
        dm = dm / g;
        r.result_num = NUM_W'(neg ? (0 - nm) : nm);
        r.result_den = DEN_W'(dm);
      end
      pending.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.result_num !== e.result_num) begin
        $error("result_num expected %0d actual %0d", e.result_num, got.result_num);
        errors++;
      end
      if (got.result_den !== e.result_den) begin
        $error("result_den expected %0d actual %0d", e.result_den, got.result_den);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  fraction_board board = new();
  bit quiet_phase = 1'b0;
  bit input_done = 1'b0;

  rational_arithmetic_reduce DUT (.*);

  always #5 clk_i = ~clk_i;

  // check results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // receiver stalls in random bursts
  initial begin
    int burst;
    forever begin
      @(negedge clk_i);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
      6: return 16'($urandom_range(0, 255)) * 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one transaction and hold it until accepted; valid drops only for an idle gap
  task automatic send_item(kind_e k, logic [15:0] a, logic [15:0] b,
                           logic [15:0] c, logic [15:0] d);
    in_item_t it;
    it.kind = k; it.first_num = a; it.first_den = b;
    it.second_num = c; it.second_den = d;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(it);
    @(negedge clk_i);
  endtask

  initial begin
    int idx;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: every operation, extremes, zero denominators and numerators
    for (int k = 0; k < 4; k++) begin
      send_item(kind_e'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(kind_e'(k), 16'h7fff, 16'h8000, 16'h8001, 16'h7fff);
      send_item(kind_e'(k), 16'd3, 16'd0, 16'd5, 16'd7);
      send_item(kind_e'(k), 16'd0, 16'hfffd, 16'd0, 16'd4);
      send_item(kind_e'(k), 16'hfffa, 16'd4, 16'd9, 16'hfff4);
    end
    send_item(KIND_DIV, 16'd5, 16'd3, 16'd0, 16'd2);
    send_item(KIND_SUB, 16'd2, 16'd3, 16'd2, 16'd3);
    // random part
    for (idx = 0; idx < 850; idx++) begin
      if (idx >= 750) quiet_phase = 1'b1;
      send_item(kind_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
    end
    in_valid_i <= 1'b0;
    input_done = 1'b1;
  end

  // wait for the last result, then a short drain
  initial begin
    wait (input_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("rational_arithmetic_reduce_tb: done, clean");
    end else begin
      $display("rational_arithmetic_reduce_tb: done, errors");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("rational_arithmetic_reduce_tb: done, errors");
    $finish;
  end
endmodule

FILE: files.f
rtl/rar_pkg.sv
rtl/rational_arithmetic_reduce.sv
dv/rational_arithmetic_reduce_tb.sv
